>>> rtl/core/lvn4_pkg.sv
package lvn4_pkg;
   localparam int VAL_W = 16;
   localparam int IDX_W = 8;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_WR_VAL = 2'd1,
      CMD_WR_PERM = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_P0    = 7'b0000010,
      ST_P1    = 7'b0000100,
      ST_P2    = 7'b0001000,
      ST_P3    = 7'b0010000,
      ST_VAL   = 7'b0100000,
      ST_BLEND = 7'b1000000
   } state_type;

   typedef struct packed {
      logic       load;
      logic [1:0] hstep;
      logic       val_rd;
      logic       blend;
      logic       next_corner;
   } ctrl_type;
endpackage

>>> rtl/core/lvn4_datapath.sv
module lvn4_datapath
   import lvn4_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     wr_val,
   input  logic                     wr_perm,
   input  logic [IDX_W-1:0]         entry_index,
   input  logic signed [VAL_W-1:0]  value_word,
   input  logic [IDX_W-1:0]         perm_word,
   input  logic [31:0]              x_coord,
   input  logic [31:0]              y_coord,
   input  logic [31:0]              z_coord,
   input  logic [31:0]              t_coord,
   input  ctrl_type                 ctrl,
   output logic [3:0]               corner,
   output logic                     blend_last,
   output logic signed [VAL_W-1:0]  noise
);
   localparam int DW = VAL_W + 1;
   localparam int FW = FRAC_BITS + 1;
   localparam int PW = DW + FW;

   logic [IDX_W-1:0] perm_mem [256];
   logic signed [VAL_W-1:0] val_mem [256];
   logic [IDX_W-1:0] perm_q, hidx, acc_idx;
   logic signed [VAL_W-1:0] val_q;
   logic [IDX_W-1:0] ix_ff, iy_ff, iz_ff, it_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff, fz_ff, ft_ff;
   logic [3:0] corner_ff;
   logic signed [VAL_W-1:0] stk_ff [4];
   logic [IDX_W-1:0] cx, cy, cz, ct;
   logic [1:0] lvl_ff;
   logic signed [VAL_W-1:0] cur_ff;
   logic signed [VAL_W-1:0] src, base, bl;
   logic [FRAC_BITS-1:0] lf;
   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod;

   assign cx = ix_ff + IDX_W'(corner_ff[0]);
   assign cy = iy_ff + IDX_W'(corner_ff[1]);
   assign cz = iz_ff + IDX_W'(corner_ff[2]);
   assign ct = it_ff + IDX_W'(corner_ff[3]);

   always_comb begin
      case (ctrl.hstep)
         2'd0: acc_idx = ct;
         2'd1: acc_idx = cz + perm_q;
         2'd2: acc_idx = cy + perm_q;
         default: acc_idx = cx + perm_q;
      endcase
   end
   assign hidx = acc_idx;

   always_ff @(posedge clock) begin
      if (wr_perm) perm_mem[entry_index] <= perm_word;
      if (wr_val) val_mem[entry_index] <= value_word;
      perm_q <= perm_mem[hidx];
      if (ctrl.val_rd) val_q <= val_mem[perm_q];
   end

   // one level per cycle while not held by rsp_stall: a + (b-a)*f, floored
   always_comb begin
      src = (lvl_ff == 2'd0) ? val_q : cur_ff;
      base = stk_ff[lvl_ff];
      case (lvl_ff)
         2'd0: lf = fx_ff;
         2'd1: lf = fy_ff;
         2'd2: lf = fz_ff;
         default: lf = ft_ff;
      endcase
      diff = DW'(src) - DW'(base);
      prod = PW'(diff) * PW'($signed({1'b0, lf}));
      bl = VAL_W'(PW'(base) + (prod >>> FRAC_BITS));
      blend_last = !corner_ff[lvl_ff] || (lvl_ff == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         ix_ff <= x_coord[FRAC_BITS +: IDX_W];
         iy_ff <= y_coord[FRAC_BITS +: IDX_W];
         iz_ff <= z_coord[FRAC_BITS +: IDX_W];
         it_ff <= t_coord[FRAC_BITS +: IDX_W];
         fx_ff <= x_coord[FRAC_BITS-1:0];
         fy_ff <= y_coord[FRAC_BITS-1:0];
         fz_ff <= z_coord[FRAC_BITS-1:0];
         ft_ff <= t_coord[FRAC_BITS-1:0];
         corner_ff <= '0;
      end else if (ctrl.next_corner) begin
         corner_ff <= corner_ff + 4'd1;
      end
      if (ctrl.load || ctrl.next_corner) begin
         lvl_ff <= 2'd0;
      end else if (ctrl.blend) begin
         lvl_ff <= lvl_ff + 2'd1;
      end
      if (ctrl.blend) begin
         if (corner_ff[lvl_ff]) begin
            cur_ff <= bl;
            if (lvl_ff == 2'd3) noise <= bl;
         end else begin
            stk_ff[lvl_ff] <= src;
         end
      end
   end
   assign corner = corner_ff;
endmodule

>>> rtl/core/lvn4_ctrl.sv
module lvn4_ctrl
   import lvn4_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic [3:0] corner,
   input  logic     blend_last,
   input  logic     rsp_stall,
   output logic     busy,
   output logic     rsp_valid,
   output ctrl_type ctrl
);
   state_type st_ff, st_in;
   logic v_ff, v_in;
   always_comb begin
      st_in = st_ff; v_in = v_ff && rsp_stall;
      ctrl = '0;
      case (st_ff)
         ST_IDLE: if (start) begin ctrl.load = 1'b1; st_in = ST_P0; end
         ST_P0: begin ctrl.hstep = 2'd0; st_in = ST_P1; end
         ST_P1: begin ctrl.hstep = 2'd1; st_in = ST_P2; end
         ST_P2: begin ctrl.hstep = 2'd2; st_in = ST_P3; end
         ST_P3: begin ctrl.hstep = 2'd3; st_in = ST_VAL; end
         ST_VAL: begin ctrl.val_rd = 1'b1; st_in = ST_BLEND; end
         ST_BLEND: begin
            // last step waits while the previous result is still stalled
            if (!(blend_last && (&corner) && v_ff && rsp_stall)) begin
               ctrl.blend = 1'b1;
               if (blend_last) begin
                  ctrl.next_corner = 1'b1;
                  if (&corner) begin v_in = 1'b1; st_in = ST_IDLE; end
                  else st_in = ST_P0;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin st_ff <= ST_IDLE; v_ff <= 1'b0; end
      else begin st_ff <= st_in; v_ff <= v_in; end
   end
   assign busy = (st_ff != ST_IDLE);
   assign rsp_valid = v_ff;
endmodule

>>> rtl/core/lattice_value_noise_4d_top.sv
// 4D lattice value noise.
// req_ channel: valid/stall; command 1/2 loads value/permutation tables
// (no response), command 0 samples, command 3 is dropped.
// rsp_ channel: valid/stall, one noise transaction per sample.
// A sample walks 16 corners: four chained permutation reads and a value
// read on single-port tables, then one blend step for each interpolation
// level the corner closes, plus one that stores its partial result unless
// all four levels close. rsp_valid rises as the controller returns to idle,
// and a new transaction can be taken in that same cycle.
// req_stall is high while a sample runs. A new sample may start while a
// result waits under rsp_stall; it then holds in its last blend step
// until that result is taken.
// Reset clears the controller only; tables must be loaded before use.
module lattice_value_noise_4d_top
   import lvn4_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic signed [31:0] req_z_coord,
   input  logic signed [31:0] req_t_coord,
   input  logic [7:0]         req_entry_index,
   input  logic signed [15:0] req_value_word,
   input  logic [7:0]         req_perm_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_noise
);
   ctrl_type ctrl;
   logic busy, acc, blend_last;
   logic [3:0] corner;
   assign req_stall = busy;
   assign acc = req_valid && !busy;
   lvn4_ctrl u_ctrl (.clock, .reset, .start(acc && req_command == CMD_SAMPLE),
      .corner, .blend_last, .rsp_stall, .busy, .rsp_valid, .ctrl);
   lvn4_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (.clock,
      .wr_val(acc && req_command == CMD_WR_VAL),
      .wr_perm(acc && req_command == CMD_WR_PERM),
      .entry_index(req_entry_index), .value_word(req_value_word),
      .perm_word(req_perm_word), .x_coord(req_x_coord), .y_coord(req_y_coord),
      .z_coord(req_z_coord), .t_coord(req_t_coord), .ctrl, .corner,
      .blend_last, .noise(rsp_noise));
endmodule

>>> tb/lattice_value_noise_4d_top_tb.sv
`timescale 1ns / 100ps

module lattice_value_noise_4d_top_tb;
   import lvn4_pkg::*;

   typedef struct {
      cmd_type            command;
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
      logic signed [31:0] t_coord;
      logic [7:0]         entry_index;
      logic signed [15:0] value_word;
      logic [7:0]         perm_word;
   } req_item_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_command;
   logic signed [31:0] req_x_coord;
   logic signed [31:0] req_y_coord;
   logic signed [31:0] req_z_coord;
   logic signed [31:0] req_t_coord;
   logic [7:0]         req_entry_index;
   logic signed [15:0] req_value_word;
   logic [7:0]         req_perm_word;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_noise;

   req_item_type       pending_q[$];
   logic signed [15:0] noise_q[$];
   logic signed [15:0] pred_values[256];
   logic [7:0]         pred_perm[256];
   int                 error_count;
   int                 sample_count;
   int                 write_count;
   bit                 stim_done;
   bit                 hold_off;
   int                 send_gap;
   int                 stall_gap;

   lattice_value_noise_4d_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .req_t_coord     (req_t_coord),
      .req_entry_index (req_entry_index),
      .req_value_word  (req_value_word),
      .req_perm_word   (req_perm_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise       (rsp_noise)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint floor_div(longint v);
      return v >>> 16;
   endfunction

   function automatic longint mix(longint a, longint b, longint f);
      return floor_div(a * (65536 - f) + b * f);
   endfunction

   function automatic longint lattice_value(logic [7:0] x, logic [7:0] y,
                                            logic [7:0] z, logic [7:0] t);
      logic [7:0] h;
      h = pred_perm[t];
      h = pred_perm[8'(z + h)];
      h = pred_perm[8'(y + h)];
      h = pred_perm[8'(x + h)];
      return longint'(pred_values[h]);
   endfunction

   function automatic logic signed [15:0] noise_at(req_item_type it);
      logic [7:0] ix, iy, iz, itt;
      longint     fx, fy, fz, ft;
      longint     slab[2];
      longint     plane[2];
      longint     r0, r1;
      ix = it.x_coord[23:16];
      iy = it.y_coord[23:16];
      iz = it.z_coord[23:16];
      itt = it.t_coord[23:16];
      fx = longint'(it.x_coord[15:0]);
      fy = longint'(it.y_coord[15:0]);
      fz = longint'(it.z_coord[15:0]);
      ft = longint'(it.t_coord[15:0]);
      for (int dt = 0; dt < 2; dt++) begin
         for (int dz = 0; dz < 2; dz++) begin
            r0 = mix(lattice_value(ix, iy, 8'(iz + dz), 8'(itt + dt)),
                     lattice_value(8'(ix + 1), iy, 8'(iz + dz), 8'(itt + dt)), fx);
            r1 = mix(lattice_value(ix, 8'(iy + 1), 8'(iz + dz), 8'(itt + dt)),
                     lattice_value(8'(ix + 1), 8'(iy + 1), 8'(iz + dz), 8'(itt + dt)),
                     fx);
            plane[dz] = mix(r0, r1, fy);
         end
         slab[dt] = mix(plane[0], plane[1], fz);
      end
      return 16'(mix(slab[0], slab[1], ft));
   endfunction

   function automatic req_item_type blank_item(cmd_type c);
      req_item_type it;
      it.command = c;
      it.x_coord = $urandom;
      it.y_coord = $urandom;
      it.z_coord = $urandom;
      it.t_coord = $urandom;
      it.entry_index = 8'($urandom);
      it.value_word = 16'($urandom);
      it.perm_word = 8'($urandom);
      return it;
   endfunction

   task automatic push_write(cmd_type c, logic [7:0] idx, logic [15:0] word);
      req_item_type it;
      it = blank_item(c);
      it.entry_index = idx;
      if (c == CMD_WR_VAL) it.value_word = word;
      else it.perm_word = word[7:0];
      pending_q.push_back(it);
   endtask

   task automatic push_sample(logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] t);
      req_item_type it;
      it = blank_item(CMD_SAMPLE);
      it.x_coord = x;
      it.y_coord = y;
      it.z_coord = z;
      it.t_coord = t;
      pending_q.push_back(it);
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_valid) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid && !req_stall) begin
            case (cmd_type'(req_command))
               CMD_WR_VAL:  pred_values[req_entry_index] = req_value_word;
               CMD_WR_PERM: pred_perm[req_entry_index] = req_perm_word;
               CMD_SAMPLE: begin
                  noise_q.push_back(noise_at('{cmd_type'(req_command), req_x_coord,
                     req_y_coord, req_z_coord, req_t_coord, req_entry_index,
                     req_value_word, req_perm_word}));
                  sample_count++;
               end
               default: ;
            endcase
            if (req_command != CMD_SAMPLE) write_count++;
         end
         if (send_gap > 0 || hold_off || pending_q.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            req_item_type it;
            it = pending_q.pop_front();
            req_valid <= 1'b1;
            req_command <= it.command;
            req_x_coord <= it.x_coord;
            req_y_coord <= it.y_coord;
            req_z_coord <= it.z_coord;
            req_t_coord <= it.t_coord;
            req_entry_index <= it.entry_index;
            req_value_word <= it.value_word;
            req_perm_word <= it.perm_word;
            send_gap <= gap_len();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (noise_q.size() == 0) begin
               $error("unexpected noise transaction %0d", rsp_noise);
               error_count++;
            end else begin
               logic signed [15:0] want;
               want = noise_q.pop_front();
               if (rsp_noise !== want) begin
                  $error("noise: expected %0d, got %0d", want, rsp_noise);
                  error_count++;
               end
            end
         end
         if (stall_gap > 0) begin
            rsp_stall <= 1'b1;
            stall_gap <= stall_gap - 1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 9) < 3) stall_gap <= gap_len();
         end
      end
   end

   initial begin
      logic [31:0] extremes[4];
      int          waited;
      extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      error_count = 0;
      sample_count = 0;
      write_count = 0;
      stim_done = 0;
      hold_off = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_command = CMD_NONE;
      req_x_coord = '0;
      req_y_coord = '0;
      req_z_coord = '0;
      req_t_coord = '0;
      req_entry_index = '0;
      req_value_word = '0;
      req_perm_word = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full table load first so that no sample reads an unwritten entry
      for (int i = 0; i < 256; i++) begin
         push_write(CMD_WR_VAL, i[7:0], i[0] ? 16'sh4000 : 16'shC000);
         push_write(CMD_WR_PERM, i[7:0], 16'(255 - i));
      end
      push_write(CMD_WR_VAL, 8'd0, 16'h7FFF);
      push_write(CMD_WR_VAL, 8'd255, 16'h8000);
      push_write(CMD_WR_PERM, 8'd0, 16'h00FF);
      pending_q.push_back(blank_item(CMD_NONE));
      for (int i = 0; i < 4; i++)
         push_sample(extremes[i], extremes[(i + 1) % 4], extremes[(i + 2) % 4],
                     extremes[(i + 3) % 4]);
      push_sample(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
      push_sample(32'h00FF_0000, 32'h00FF_8000, 32'hFFFF_0001, 32'h0001_7FFF);
      for (int i = 0; i < 6; i++)
         push_sample($urandom, $urandom, $urandom, $urandom);
      drain();
      hold_off = 1;
      while (noise_q.size() != 0) @(posedge clock);
      hold_off = 0;

      for (int i = 0; i < 572; i++) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 30) push_write(CMD_WR_VAL, 8'($urandom), 16'($urandom));
         else if (r < 45) push_write(CMD_WR_PERM, 8'($urandom), 16'($urandom));
         else if (r < 48) pending_q.push_back(blank_item(CMD_NONE));
         else pending_q.push_back(blank_item(CMD_SAMPLE));
         if (i == 286) begin
            drain();
            hold_off = 1;
            while (noise_q.size() != 0) @(posedge clock);
            hold_off = 0;
         end
      end
      drain();
      stim_done = 1;
      waited = 0;
      while (noise_q.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (noise_q.size() != 0) begin
         $error("%0d noise transactions never arrived", noise_q.size());
         error_count++;
      end
      $display("Ran %0d samples and %0d table writes or dropped commands,",
               sample_count, write_count);
      $display("with random gaps and stalls on both channels.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
